// ===== rtl/bdeq_pkg.sv =====
package bdeq_pkg;

   // built-in ring depth and derived widths
   localparam int DEPTH  = 64;
   localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int CAP_W  = 7;
   localparam int WORD_W = 32;
   localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   typedef logic [PTR_W-1:0]  ptr_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [CAP_W-1:0]  cap_type;
   typedef logic [WORD_W-1:0] word_type;

   // action codes
   typedef enum logic [2:0] {
      ACT_PUSH_FRONT = 3'd0,
      ACT_PUSH_REAR  = 3'd1,
      ACT_POP_FRONT  = 3'd2,
      ACT_POP_REAR   = 3'd3,
      ACT_QUERY      = 3'd4
   } action_type;

   typedef struct packed {
      action_type               action;
      logic signed [WORD_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic                     ok;
      logic signed [WORD_W-1:0] front_word;
      logic signed [WORD_W-1:0] rear_word;
      logic                     is_empty;
      logic                     is_full;
   } rsp_type;

   // write request into the ring store
   typedef struct packed {
      logic     en;
      ptr_type  addr;
      word_type data;
   } ring_wr_type;

   // a + b modulo DEPTH, both operands below DEPTH
   function automatic ptr_type ring_add(ptr_type a, ptr_type b);
      logic [PTR_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= (PTR_W+1)'(DEPTH)) begin
         s = s - (PTR_W+1)'(DEPTH);
      end
      return s[PTR_W-1:0];
   endfunction

   // a - 1 modulo DEPTH
   function automatic ptr_type ring_dec(ptr_type a);
      ptr_type r;
      if (a == '0) begin
         r = PTR_W'(DEPTH - 1);
      end else begin
         r = a - PTR_W'(1);
      end
      return r;
   endfunction

endpackage

// ===== rtl/bdeq_ring.sv =====
module bdeq_ring (
   input  logic                  clock,
   input  bdeq_pkg::ring_wr_type wr,
   input  bdeq_pkg::ptr_type     rd_a_addr,
   input  bdeq_pkg::ptr_type     rd_b_addr,
   output bdeq_pkg::word_type    rd_a_data,
   output bdeq_pkg::word_type    rd_b_data
);
   import bdeq_pkg::*;

   word_type mem [DEPTH];
   word_type rd_a_ff;
   word_type rd_b_ff;

   // single write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // two registered read ports, same-cycle write forwarded
   always_ff @(posedge clock) begin
      if (wr.en && (wr.addr == rd_a_addr)) begin
         rd_a_ff <= wr.data;
      end else begin
         rd_a_ff <= mem[rd_a_addr];
      end
      if (wr.en && (wr.addr == rd_b_addr)) begin
         rd_b_ff <= wr.data;
      end else begin
         rd_b_ff <= mem[rd_b_addr];
      end
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

// ===== rtl/bounded_double_ended_queue.sv =====
// Bounded double-ended queue of 32-bit signed words held in a 64-entry ring.
// Request channel: drive req_item (action, value) and raise start; the item
// is taken at any clock edge where start is high and busy is low. busy stays
// low, so one item can be taken every cycle.
// Response channel: every item gives exactly one response, shown on rsp_item
// with rsp_valid high for one cycle, in the cycle after the item was taken
// (throughput 1 item per cycle). The receiver cannot stall the
// response; it must capture it in that cycle.
// The rate is set by the ring store: the new front and rear positions are
// worked out in the request cycle and read through two registered read ports,
// with a write of the same cycle forwarded to the read data.
// Control port: csr_data carries the capacity, written when csr_valid and
// csr_ready are both high (csr_ready is always high). Capacity above the ring
// depth acts as the ring depth; write it only while no response is pending.
// Reset (synchronous, active high) empties the queue, sets capacity to 64 and
// drops rsp_valid. Store contents are not cleared; only pushed entries are read.
module bounded_double_ended_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  bdeq_pkg::req_type req_item,
   output logic              rsp_valid,
   output bdeq_pkg::rsp_type rsp_item,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  bdeq_pkg::cap_type csr_data
);
   import bdeq_pkg::*;

   cap_type     capacity_ff;
   ptr_type     front_ff;
   ptr_type     front_in;
   cnt_type     count_ff;
   cnt_type     count_in;
   logic        rsp_valid_ff;
   logic        ok_ff;
   logic        ok_in;
   logic        empty_ff;
   logic        full_ff;
   logic        accept;
   logic        can_push;
   logic        can_pop;
   cnt_type     cap_eff;
   ring_wr_type wr;
   ptr_type     rd_front_addr;
   ptr_type     rd_rear_addr;
   ptr_type     rear_offset;
   word_type    rd_front_data;
   word_type    rd_rear_data;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   // capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_W'(64);
      end else if (csr_valid && csr_ready) begin
         capacity_ff <= csr_data;
      end
   end

   // capacity saturates at the ring depth
   always_comb begin
      if (CMP_W'(capacity_ff) > CMP_W'(DEPTH)) begin
         cap_eff = CNT_W'(DEPTH);
      end else begin
         cap_eff = CNT_W'(capacity_ff);
      end
   end

   assign can_push = count_ff < cap_eff;
   assign can_pop  = count_ff != '0;

   // next pointer, count and store write for the requested action
   always_comb begin
      front_in = front_ff;
      count_in = count_ff;
      ok_in    = 1'b0;
      wr.en    = 1'b0;
      wr.addr  = front_ff;
      wr.data  = word_type'(req_item.value);
      case (req_item.action)
         ACT_PUSH_FRONT: begin
            if (can_push) begin
               front_in = ring_dec(front_ff);
               wr.en    = accept;
               wr.addr  = ring_dec(front_ff);
               count_in = count_ff + CNT_W'(1);
               ok_in    = 1'b1;
            end
         end
         ACT_PUSH_REAR: begin
            if (can_push) begin
               wr.en    = accept;
               wr.addr  = ring_add(front_ff, PTR_W'(count_ff));
               count_in = count_ff + CNT_W'(1);
               ok_in    = 1'b1;
            end
         end
         ACT_POP_FRONT: begin
            if (can_pop) begin
               front_in = ring_add(front_ff, PTR_W'(1));
               count_in = count_ff - CNT_W'(1);
               ok_in    = 1'b1;
            end
         end
         ACT_POP_REAR: begin
            if (can_pop) begin
               count_in = count_ff - CNT_W'(1);
               ok_in    = 1'b1;
            end
         end
         ACT_QUERY: begin
            ok_in = 1'b1;
         end
         default: begin
            ok_in = 1'b0;
         end
      endcase
   end

   // read positions of the front and rear after the action
   assign rear_offset   = (count_in == '0) ? '0 : PTR_W'(count_in - CNT_W'(1));
   assign rd_front_addr = front_in;
   assign rd_rear_addr  = ring_add(front_in, rear_offset);

   // queue state
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
      end else if (accept) begin
         front_ff <= front_in;
         count_ff <= count_in;
      end
   end

   // response strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= accept;
      end
   end

   // response flags
   always_ff @(posedge clock) begin
      if (accept) begin
         ok_ff    <= ok_in;
         empty_ff <= count_in == '0;
         full_ff  <= count_in >= cap_eff;
      end
   end

   bdeq_ring u_ring (
      .clock     (clock),
      .wr        (wr),
      .rd_a_addr (rd_front_addr),
      .rd_b_addr (rd_rear_addr),
      .rd_a_data (rd_front_data),
      .rd_b_data (rd_rear_data)
   );

   // response transfer
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_item.ok         = ok_ff;
   assign rsp_item.front_word = empty_ff ? '1 : rd_front_data;
   assign rsp_item.rear_word  = empty_ff ? '1 : rd_rear_data;
   assign rsp_item.is_empty   = empty_ff;
   assign rsp_item.is_full    = full_ff;

endmodule

// ===== rtl/bdeq_check.sv =====
module bdeq_check (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input bdeq_pkg::req_type req_item,
   input logic              rsp_valid,
   input bdeq_pkg::rsp_type rsp_item,
   input logic              csr_valid,
   input logic              csr_ready,
   input bdeq_pkg::cap_type csr_data
);
   import bdeq_pkg::*;

   // one response in the cycle after each request transfer
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (rsp_valid == $past(start && !busy && !reset)))
      else $error("response strobe does not follow request transfer");

   // an empty queue reports all ones at both ends
   a_empty_words: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.is_empty) |->
         ((rsp_item.front_word == '1) && (rsp_item.rear_word == '1)))
      else $error("empty queue reports a word");

   // a query always succeeds
   a_query_ok: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_item.action == ACT_QUERY)) |=> rsp_item.ok)
      else $error("query refused");

   // a pop taken in the same cycle as an empty report is refused
   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.is_empty && start && !busy &&
       ((req_item.action == ACT_POP_FRONT) || (req_item.action == ACT_POP_REAR)))
      |=> (!rsp_item.ok && rsp_item.is_empty))
      else $error("pop from empty queue accepted");

endmodule

bind bounded_double_ended_queue bdeq_check u_check (.*);

// ===== bench/bounded_double_ended_queue_checker.sv =====
`timescale 1ns / 100ps

module bounded_double_ended_queue_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  bdeq_pkg::req_type req_item,
   input  logic              rsp_valid,
   input  bdeq_pkg::rsp_type rsp_item,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  bdeq_pkg::cap_type csr_data,
   output int                fail_count,
   output int                pending,
   output int                checked,
   output int                refused
);
   import bdeq_pkg::*;

   localparam cap_type CAP_AT_RESET = cap_type'(DEPTH);

   // shadow of the deque: ring contents, front position and word count
   word_type    ring_copy [DEPTH];
   int unsigned front_pos;
   int unsigned word_cnt;
   cap_type     cap_reg;

   // responses owed by the block, oldest first
   rsp_type outcomes [$];

   initial begin
      fail_count = 0;
      pending    = 0;
      checked    = 0;
      refused    = 0;
   end

   // carry out one action on the shadow deque and return the response it owes
   function automatic rsp_type apply_action(req_type r);
      int unsigned limit;
      logic [2:0]  code;
      rsp_type     o;
      limit = (cap_reg > DEPTH) ? DEPTH : cap_reg;
      code  = r.action;
      o     = '0;
      case (code)
         ACT_PUSH_FRONT: begin
            if (word_cnt < limit) begin
               front_pos = (front_pos + DEPTH - 1) % DEPTH;
               ring_copy[front_pos] = r.value;
               word_cnt++;
               o.ok = 1'b1;
            end
         end
         ACT_PUSH_REAR: begin
            if (word_cnt < limit) begin
               ring_copy[(front_pos + word_cnt) % DEPTH] = r.value;
               word_cnt++;
               o.ok = 1'b1;
            end
         end
         ACT_POP_FRONT: begin
            if (word_cnt != 0) begin
               front_pos = (front_pos + 1) % DEPTH;
               word_cnt--;
               o.ok = 1'b1;
            end
         end
         ACT_POP_REAR: begin
            if (word_cnt != 0) begin
               word_cnt--;
               o.ok = 1'b1;
            end
         end
         ACT_QUERY: begin
            o.ok = 1'b1;
         end
         default: begin
            // unknown codes leave the deque alone and report ok low
         end
      endcase
      // empty deque shows all ones at both ends
      if (word_cnt == 0) begin
         o.front_word = '1;
         o.rear_word  = '1;
      end else begin
         o.front_word = ring_copy[front_pos];
         o.rear_word  = ring_copy[(front_pos + word_cnt - 1) % DEPTH];
      end
      o.is_empty = (word_cnt == 0);
      o.is_full  = (word_cnt >= limit);
      return o;
   endfunction

   // report one field; returns 1 on a mismatch
   function automatic int field_wrong(string name, logic [WORD_W-1:0] want,
                                      logic [WORD_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   // per clock: check the response transfer, then log the request transfer and the capacity write
   always @(posedge clock) begin
      rsp_type want;
      int      bad;
      if (reset) begin
         front_pos = 0;
         word_cnt  = 0;
         cap_reg   = CAP_AT_RESET;
         outcomes.delete();
      end else begin
         if (rsp_valid === 1'b1) begin
            if (outcomes.size() == 0) begin
               $error("response transfer with no response owed");
               fail_count++;
            end else begin
               want = outcomes.pop_front();
               bad  = field_wrong("ok", want.ok, rsp_item.ok);
               bad += field_wrong("front_word", want.front_word, rsp_item.front_word);
               bad += field_wrong("rear_word", want.rear_word, rsp_item.rear_word);
               bad += field_wrong("is_empty", want.is_empty, rsp_item.is_empty);
               bad += field_wrong("is_full", want.is_full, rsp_item.is_full);
               if (bad != 0) begin
                  fail_count++;
               end
               if (!want.ok) begin
                  refused++;
               end
               checked++;
            end
         end
         // request taken this edge uses the capacity held before it
         if (start === 1'b1 && busy === 1'b0) begin
            outcomes.push_back(apply_action(req_item));
         end
         if (csr_valid === 1'b1 && csr_ready === 1'b1) begin
            cap_reg = csr_data;
         end
      end
      pending = outcomes.size();
   end

endmodule

// ===== bench/bounded_double_ended_queue_tb.sv =====
`timescale 1ns / 100ps

module bounded_double_ended_queue_tb;
   import bdeq_pkg::*;

   localparam real CLK_PERIOD        = 12.0;
   localparam int  RESET_CYCLES      = 9;
   localparam int  DRAIN_CYCLES      = 3;
   localparam int  DRAIN_LIMIT       = 1000;
   localparam int  ITEMS_PER_SETTING = 204;
   localparam int  SETTING_COUNT     = 8;
   localparam real TIMEOUT_NS        = 5.0e6;

   localparam logic [2:0] ACT_CODE_MAX = 3'd7;
   localparam word_type   WORD_MIN     = 32'h8000_0000;
   localparam word_type   WORD_MAX     = 32'h7FFF_FFFF;
   localparam word_type   WORD_ONES    = 32'hFFFF_FFFF;
   localparam word_type   WORD_ZERO    = 32'h0000_0000;

   // request mix for one burst of random traffic
   typedef enum int {FILLING, DRAINING, CHURNING} mix_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    start     = 1'b0;
   logic    busy;
   req_type req_item  = '0;
   logic    rsp_valid;
   rsp_type rsp_item;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   cap_type csr_data  = '0;

   int fail_count;
   int pending;
   int checked;
   int refused;
   int items_sent       = 0;
   int settings_written = 0;

   always #(CLK_PERIOD / 2.0) clock = ~clock;

   bounded_double_ended_queue i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   bounded_double_ended_queue_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_valid  (rsp_valid),
      .rsp_item   (rsp_item),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked),
      .refused    (refused)
   );

   // one request transfer, after an optional gap
   task automatic send(action_type act, word_type value, int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= '{act, value};
      do @(posedge clock); while (busy);
      items_sent++;
   endtask

   // hold off until every owed response has come back
   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // capacity transfer, only with the block idle
   task automatic write_capacity(cap_type cap);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data  <= cap;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      settings_written++;
   endtask

   function automatic word_type random_word();
      case ($urandom_range(0, 23))
         0:       return WORD_MIN;
         1:       return WORD_MAX;
         2:       return WORD_ONES;
         3:       return WORD_ZERO;
         default: return $urandom;
      endcase
   endfunction

   // pick an action according to the burst mix
   function automatic req_type random_item(mix_type mix);
      int      pick;
      int      t_pf, t_pr, t_pof, t_por, t_q;
      req_type r;
      case (mix)
         FILLING:  begin t_pf = 40; t_pr = 80; t_pof = 88; t_por = 95; t_q = 98; end
         DRAINING: begin t_pf = 10; t_pr = 20; t_pof = 50; t_por = 80; t_q = 94; end
         default:  begin t_pf = 22; t_pr = 44; t_pof = 66; t_por = 88; t_q = 96; end
      endcase
      pick = $urandom_range(0, 99);
      if (pick < t_pf) begin
         r.action = ACT_PUSH_FRONT;
      end else if (pick < t_pr) begin
         r.action = ACT_PUSH_REAR;
      end else if (pick < t_pof) begin
         r.action = ACT_POP_FRONT;
      end else if (pick < t_por) begin
         r.action = ACT_POP_REAR;
      end else if (pick < t_q) begin
         r.action = ACT_QUERY;
      end else begin
         r.action = action_type'(3'($urandom_range(int'(ACT_QUERY) + 1, int'(ACT_CODE_MAX))));
      end
      r.value = random_word();
      return r;
   endfunction

   // mostly back to back, some short gaps, a few long ones; none when steady
   function automatic int random_gap(bit steady);
      int pick;
      if (steady) begin
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
         return 0;
      end else if (pick < 93) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   initial begin : stimulus
      cap_type caps [SETTING_COUNT];
      int      burst_left;
      mix_type mix;
      bit      steady;
      req_type item;
      caps       = '{7'd64, 7'd127, 7'd1, 7'd0, 7'd2, 7'd100, 7'd5, 7'd64};
      caps[SETTING_COUNT-1] = cap_type'($urandom_range(3, 126));
      burst_left = 0;
      mix        = CHURNING;
      steady     = 1'b0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // small capacity: refused pops, wrap below index zero, push when full
      write_capacity(7'd3);
      send(ACT_POP_FRONT, WORD_ZERO, 0);
      send(ACT_POP_REAR, WORD_ONES, 0);
      send(ACT_QUERY, WORD_MAX, 0);
      send(ACT_PUSH_FRONT, WORD_MIN, 0);
      send(ACT_PUSH_REAR, WORD_MAX, 0);
      send(ACT_PUSH_FRONT, WORD_ONES, 0);
      send(ACT_PUSH_REAR, WORD_ZERO, 0);
      send(ACT_PUSH_FRONT, WORD_MAX, 0);
      // unknown action codes
      for (int c = int'(ACT_QUERY) + 1; c <= int'(ACT_CODE_MAX); c++) begin
         send(action_type'(3'(c)), WORD_MIN, 0);
      end
      send(ACT_POP_REAR, WORD_ZERO, 0);
      send(ACT_POP_FRONT, WORD_ZERO, 0);
      send(ACT_PUSH_REAR, WORD_ZERO, 0);
      send(ACT_PUSH_REAR, 32'hAAAA_5555, 0);

      // capacity dropped below the word count: words stay, pushes refused
      write_capacity(7'd1);
      send(ACT_PUSH_FRONT, 32'h5555_AAAA, 0);
      send(ACT_QUERY, WORD_ZERO, 0);
      send(ACT_POP_FRONT, WORD_ZERO, 0);
      send(ACT_POP_REAR, WORD_ZERO, 0);
      send(ACT_QUERY, WORD_ZERO, 0);
      send(ACT_POP_FRONT, WORD_ZERO, 0);

      // zero capacity: empty and full at once
      write_capacity(7'd0);
      send(ACT_PUSH_REAR, WORD_MAX, 0);
      send(ACT_QUERY, WORD_ZERO, 0);

      // random bursts under each capacity setting; contents carry over
      foreach (caps[p]) begin
         write_capacity(caps[p]);
         for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(20, 80);
               mix        = mix_type'($urandom_range(0, 2));
               steady     = ($urandom_range(0, 3) == 0);
            end
            burst_left--;
            if ($urandom_range(0, 149) == 0) begin
               wait_idle();
            end
            item = random_item(mix);
            send(item.action, item.value, random_gap(steady));
         end
      end

      // drain, bounded
      start <= 1'b0;
      @(posedge clock);
      for (int n = 0; n < DRAIN_LIMIT && pending != 0; n++) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending != 0) begin
         $error("%0d responses never arrived", pending);
      end

      $display("Sent %0d deque actions under %0d capacity settings, zero and above depth included",
               items_sent, settings_written);
      $display("Checked %0d responses, %0d of them refused or unknown actions",
               checked, refused);
      if (fail_count == 0 && pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // hard stop in case the handshake hangs
   initial begin
      #(TIMEOUT_NS);
      $display("Some tests failed");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/bdeq_pkg.sv
rtl/bdeq_ring.sv
rtl/bounded_double_ended_queue.sv
rtl/bdeq_check.sv
bench/bounded_double_ended_queue_checker.sv
bench/bounded_double_ended_queue_tb.sv
